// ===== rtl/rrab_pkg.sv =====
// rounded rectangle alpha blend: shared types, register codes and constants
// used by every module of the block but the queue; depends on nothing
`default_nettype none

package rrab_pkg;

  typedef struct packed {
    logic [7:0] old_red;
    logic [7:0] old_green;
    logic [7:0] old_blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] new_red;
    logic [7:0] new_green;
    logic [7:0] new_blue;
    logic       last_pixel;
  } blend_t;

  // control from the register block to the front end
  typedef struct packed {
    logic size_write;
    logic busy;
  } cfg_ctrl_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int SIDE_REG_W  = 13;
  localparam int PERMYRIAD_W = 14;

  localparam logic [CFG_INDEX_W-1:0] REG_RECT_WIDTH       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RECT_HEIGHT      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RADIUS_PERMYRIAD = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_LEVEL      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FILL_COLOR       = 3'd4;

  localparam logic [SIDE_REG_W-1:0]  RESET_RECT_WIDTH  = 13'd1;
  localparam logic [SIDE_REG_W-1:0]  RESET_RECT_HEIGHT = 13'd1;
  localparam logic [PERMYRIAD_W-1:0] RESET_PERMYRIAD   = 14'd0;
  localparam logic [7:0]             RESET_ALPHA       = 8'd255;
  localparam logic [23:0]            RESET_FILL        = 24'd0;

  localparam logic [7:0] ALPHA_MAX = 8'd255;

  // round to nearest before dividing by 10000
  localparam int ROUND_BIAS = 5000;
  // floor(x / 10000) == (x * RECIP) >> RECIP_SHIFT for every x below 2**30
  localparam int              RECIP_W     = 31;
  localparam logic [30:0]     RECIP       = 31'd1759218605;
  localparam int              RECIP_SHIFT = 44;

  // cycles the radius chain needs after a register write
  localparam int         SETTLE_W      = 3;
  localparam logic [2:0] SETTLE_CYCLES = 3'd4;

endpackage

`default_nettype wire

// ===== rtl/rrab_cfg.sv =====
// register block and corner radius chain: holds the configuration registers,
// derives the used sides, radius and radius squared; uses rrab_pkg
`default_nettype none

module rrab_cfg #(
  parameter int MAX_SIDE = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [rrab_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rrab_pkg::CFG_DATA_W-1:0]  cfg_data,
  output      rrab_pkg::cfg_ctrl_t              ctrl,
  output      logic [$clog2(MAX_SIDE+1)-1:0]    w_used,
  output      logic [$clog2(MAX_SIDE+1)-1:0]    h_used,
  output      logic [$clog2(MAX_SIDE/2+1)-1:0]  radius,
  output      logic [2*$clog2(MAX_SIDE/2+1)-1:0] rsq,
  output      logic [7:0]                       alpha,
  output      logic [23:0]                      fill
);

  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int RW = $clog2(MAX_SIDE / 2 + 1);
  localparam int PW = rrab_pkg::PERMYRIAD_W + SW;
  localparam int MW = PW + rrab_pkg::RECIP_W;
  localparam int QW = MW - rrab_pkg::RECIP_SHIFT;

  logic [rrab_pkg::SIDE_REG_W-1:0]  width_reg;
  logic [rrab_pkg::SIDE_REG_W-1:0]  height_reg;
  logic [rrab_pkg::PERMYRIAD_W-1:0] permyriad;
  logic [rrab_pkg::SETTLE_W-1:0]    settle;

  logic [SW-1:0] w_comb;
  logic [SW-1:0] h_comb;
  logic [SW-1:0] m_comb;
  logic [SW-1:0] m_q;
  logic [SW-1:0] m2_q;
  logic [PW-1:0] prod_q;
  logic [MW-1:0] scaled_q;
  logic [QW-1:0] quot;
  logic [RW-1:0] half;
  logic [RW-1:0] radius_next;

  function automatic logic [SW-1:0] side_used(input logic [rrab_pkg::SIDE_REG_W-1:0] v);
    if (v == '0) begin
      side_used = SW'(1);
    end else if (int'(v) > MAX_SIDE) begin
      side_used = SW'(MAX_SIDE);
    end else begin
      side_used = SW'(v);
    end
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= rrab_pkg::RESET_RECT_WIDTH;
      height_reg <= rrab_pkg::RESET_RECT_HEIGHT;
      permyriad  <= rrab_pkg::RESET_PERMYRIAD;
      alpha      <= rrab_pkg::RESET_ALPHA;
      fill       <= rrab_pkg::RESET_FILL;
      settle     <= rrab_pkg::SETTLE_CYCLES;
    end else begin
      if (cfg_valid) begin
        settle <= rrab_pkg::SETTLE_CYCLES;
        unique case (cfg_index)
          rrab_pkg::REG_RECT_WIDTH:       width_reg  <= cfg_data[rrab_pkg::SIDE_REG_W-1:0];
          rrab_pkg::REG_RECT_HEIGHT:      height_reg <= cfg_data[rrab_pkg::SIDE_REG_W-1:0];
          rrab_pkg::REG_RADIUS_PERMYRIAD: permyriad  <= cfg_data[rrab_pkg::PERMYRIAD_W-1:0];
          rrab_pkg::REG_ALPHA_LEVEL:      alpha      <= cfg_data[7:0];
          rrab_pkg::REG_FILL_COLOR:       fill       <= cfg_data[23:0];
          default: ;
        endcase
      end else if (settle != '0) begin
        settle <= settle - rrab_pkg::SETTLE_W'(1);
      end
    end
  end

  always_comb begin
    ctrl.size_write = cfg_valid && ((cfg_index == rrab_pkg::REG_RECT_WIDTH) ||
                                    (cfg_index == rrab_pkg::REG_RECT_HEIGHT));
    ctrl.busy       = (settle != '0);
  end

  assign w_comb = side_used(width_reg);
  assign h_comb = side_used(height_reg);
  assign m_comb = (w_comb < h_comb) ? w_comb : h_comb;

  // constant division by 10000 through a reciprocal, then clamp to half the side
  assign quot        = scaled_q[MW-1:rrab_pkg::RECIP_SHIFT];
  assign half        = RW'(m2_q >> 1);
  assign radius_next = (quot > QW'(half)) ? half : RW'(quot);

  always_ff @(posedge clk) begin
    w_used   <= w_comb;
    h_used   <= h_comb;
    m_q      <= m_comb;
    prod_q   <= PW'(permyriad) * PW'(m_comb) + PW'(rrab_pkg::ROUND_BIAS);
    m2_q     <= m_q;
    scaled_q <= MW'(prod_q) * MW'(rrab_pkg::RECIP);
    radius   <= radius_next;
    rsq      <= (2*RW)'(radius) * (2*RW)'(radius);
  end

endmodule

`default_nettype wire

// ===== rtl/rrab_front.sv =====
// front end: accepts pixels, keeps the raster position and classifies each
// pixel against the corners before queueing it; uses rrab_pkg
`default_nettype none

module rrab_front #(
  parameter int MAX_SIDE = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire rrab_pkg::cfg_ctrl_t             ctrl,
  input  wire logic [$clog2(MAX_SIDE+1)-1:0]   w_used,
  input  wire logic [$clog2(MAX_SIDE+1)-1:0]   h_used,
  input  wire logic [$clog2(MAX_SIDE/2+1)-1:0] radius,
  input  wire logic                            pixel_valid,
  output      logic                            pixel_stall,
  input  wire rrab_pkg::pixel_t                pixel,
  input  wire logic                            q_full,
  output      logic                            q_push,
  output      rrab_pkg::pixel_t                q_pixel,
  output      logic [$clog2(MAX_SIDE/2+1)-1:0] q_dx,
  output      logic [$clog2(MAX_SIDE/2+1)-1:0] q_dy,
  output      logic                            q_corner,
  output      logic                            q_last
);

  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int RW = $clog2(MAX_SIDE / 2 + 1);
  localparam int CW = $clog2(MAX_SIDE);

  logic [CW-1:0] col;
  logic [CW-1:0] row;
  logic [SW-1:0] col_x;
  logic [SW-1:0] row_x;
  logic [SW-1:0] rad_x;
  logic [SW-1:0] dx_x;
  logic [SW-1:0] dy_x;
  logic          left;
  logic          right;
  logic          top;
  logic          bottom;
  logic          col_end;
  logic          row_end;

  assign col_x = SW'(col);
  assign row_x = SW'(row);
  assign rad_x = SW'(radius);

  assign left   = col_x < rad_x;
  assign right  = col_x >= (w_used - rad_x);
  assign top    = row_x < rad_x;
  assign bottom = row_x >= (h_used - rad_x);

  // offsets from the corner centers, lopsided as the fill routine has them
  assign dx_x = left ? (rad_x - SW'(1) - col_x) : (col_x - (w_used - rad_x));
  assign dy_x = top  ? (rad_x - SW'(1) - row_x) : (row_x - (h_used - rad_x));

  assign col_end = (col_x == (w_used - SW'(1)));
  assign row_end = (row_x == (h_used - SW'(1)));

  assign pixel_stall = q_full || ctrl.busy;
  assign q_push      = pixel_valid && !pixel_stall;
  assign q_pixel     = pixel;
  assign q_dx        = RW'(dx_x);
  assign q_dy        = RW'(dy_x);
  assign q_corner    = (radius != '0) && (left || right) && (top || bottom);
  assign q_last      = col_end && row_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (ctrl.size_write) begin
      col <= '0;
      row <= '0;
    end else if (q_push) begin
      if (col_end) begin
        col <= '0;
        row <= row_end ? '0 : (row + CW'(1));
      end else begin
        col <= col + CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rrab_fifo.sv =====
// small flop queue between the front and back ends, head entry read
// combinationally; standalone, no package needed
`default_nettype none

module rrab_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output      logic [WIDTH-1:0] rdata,
  output      logic             full,
  output      logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;

  assign rdata = mem[rd_ptr];
  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : (wr_ptr + AW'(1));
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : (rd_ptr + AW'(1));
      end
      unique case ({push, pop})
        2'b10:   count <= count + (AW+1)'(1);
        2'b01:   count <= count - (AW+1)'(1);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rrab_back.sv =====
// back end: arc test and per-channel blend in two stages ending in the
// output register; uses rrab_pkg
`default_nettype none

module rrab_back #(
  parameter int MAX_SIDE = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              q_empty,
  output      logic                              q_pop,
  input  wire rrab_pkg::pixel_t                  q_pixel,
  input  wire logic [$clog2(MAX_SIDE/2+1)-1:0]   q_dx,
  input  wire logic [$clog2(MAX_SIDE/2+1)-1:0]   q_dy,
  input  wire logic                              q_corner,
  input  wire logic                              q_last,
  input  wire logic [7:0]                        alpha,
  input  wire logic [23:0]                       fill,
  input  wire logic [2*$clog2(MAX_SIDE/2+1)-1:0] rsq,
  output      logic                              blend_valid,
  input  wire logic                              blend_stall,
  output      rrab_pkg::blend_t                  blend
);

  localparam int RW = $clog2(MAX_SIDE / 2 + 1);
  localparam int DW = 2 * RW + 1;

  logic              en;
  logic              s1_valid;
  logic [2*RW-1:0]   s1_sqx;
  logic [2*RW-1:0]   s1_sqy;
  logic              s1_corner;
  logic              s1_last;
  rrab_pkg::pixel_t  s1_pixel;
  logic [15:0]       s1_mix_r;
  logic [15:0]       s1_mix_g;
  logic [15:0]       s1_mix_b;
  logic [DW-1:0]     dist_sq;
  logic              outside;
  rrab_pkg::blend_t  blend_next;

  function automatic logic [15:0] mix(input logic [7:0] f, input logic [7:0] o,
                                      input logic [7:0] a);
    mix = 16'(f) * 16'(a) + 16'(o) * 16'(rrab_pkg::ALPHA_MAX - a);
  endfunction

  // exact x / 255 for any x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] t;
    t = x + 16'd1 + (x >> 8);
    div255 = t[15:8];
  endfunction

  assign en    = !(blend_valid && blend_stall);
  assign q_pop = en && !q_empty;

  assign dist_sq = DW'(s1_sqx) + DW'(s1_sqy);
  assign outside = s1_corner && (dist_sq > DW'(rsq));

  always_comb begin
    blend_next.new_red    = outside ? s1_pixel.old_red   : div255(s1_mix_r);
    blend_next.new_green  = outside ? s1_pixel.old_green : div255(s1_mix_g);
    blend_next.new_blue   = outside ? s1_pixel.old_blue  : div255(s1_mix_b);
    blend_next.last_pixel = s1_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      blend_valid <= 1'b0;
    end else if (en) begin
      s1_valid    <= q_pop;
      blend_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sqx    <= (2*RW)'(q_dx) * (2*RW)'(q_dx);
      s1_sqy    <= (2*RW)'(q_dy) * (2*RW)'(q_dy);
      s1_corner <= q_corner;
      s1_last   <= q_last;
      s1_pixel  <= q_pixel;
      s1_mix_r  <= mix(fill[23:16], q_pixel.old_red, alpha);
      s1_mix_g  <= mix(fill[15:8], q_pixel.old_green, alpha);
      s1_mix_b  <= mix(fill[7:0], q_pixel.old_blue, alpha);
      blend     <= blend_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rounded_rect_alpha_blend.sv =====
// top level of the rounded rectangle alpha blend: register block, front end,
// queue and back end; uses rrab_pkg, rrab_cfg, rrab_front, rrab_fifo, rrab_back
//
//   channel  dir  handshake              payload
//   pixel    in   pixel_valid/stall      rrab_pkg::pixel_t, one background pixel
//   blend    out  blend_valid/stall      rrab_pkg::blend_t, one result pixel
//   cfg      in   cfg_valid/ready        cfg_index, cfg_data
//
// one pixel per clock sustained unless a side stalls or the radius chain
// settles; an accepted pixel passes the queue, the stage one registers and
// the output register, and the queue lets either side stall while the other
// goes on. after reset and after any register write the pixel input stalls
// while the radius chain (permyriad product, reciprocal multiply by 1/10000,
// clamp, square) settles. rst is synchronous and active high.
`default_nettype none

module rounded_rect_alpha_blend #(
  parameter int MAX_SIDE    = 4096,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             pixel_valid,
  output      logic                             pixel_stall,
  input  wire rrab_pkg::pixel_t                 pixel,
  output      logic                             blend_valid,
  input  wire logic                             blend_stall,
  output      rrab_pkg::blend_t                 blend,
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [rrab_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rrab_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int RW = $clog2(MAX_SIDE / 2 + 1);
  localparam int EW = $bits(rrab_pkg::pixel_t) + 2 * RW + 2;

  rrab_pkg::cfg_ctrl_t ctrl;
  logic [SW-1:0]       w_used;
  logic [SW-1:0]       h_used;
  logic [RW-1:0]       radius;
  logic [2*RW-1:0]     rsq;
  logic [7:0]          alpha;
  logic [23:0]         fill;

  logic                fifo_push;
  logic                fifo_pop;
  logic                fifo_full;
  logic                fifo_empty;
  logic [EW-1:0]       fifo_wdata;
  logic [EW-1:0]       fifo_rdata;

  rrab_pkg::pixel_t    f_pixel;
  logic [RW-1:0]       f_dx;
  logic [RW-1:0]       f_dy;
  logic                f_corner;
  logic                f_last;
  rrab_pkg::pixel_t    b_pixel;
  logic [RW-1:0]       b_dx;
  logic [RW-1:0]       b_dy;
  logic                b_corner;
  logic                b_last;

  rrab_cfg #(.MAX_SIDE(MAX_SIDE)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .w_used    (w_used),
    .h_used    (h_used),
    .radius    (radius),
    .rsq       (rsq),
    .alpha     (alpha),
    .fill      (fill)
  );

  rrab_front #(.MAX_SIDE(MAX_SIDE)) u_front (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .w_used      (w_used),
    .h_used      (h_used),
    .radius      (radius),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .q_full      (fifo_full),
    .q_push      (fifo_push),
    .q_pixel     (f_pixel),
    .q_dx        (f_dx),
    .q_dy        (f_dy),
    .q_corner    (f_corner),
    .q_last      (f_last)
  );

  assign fifo_wdata = {f_pixel, f_dx, f_dy, f_corner, f_last};
  assign {b_pixel, b_dx, b_dy, b_corner, b_last} = fifo_rdata;

  rrab_fifo #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (fifo_push),
    .wdata (fifo_wdata),
    .pop   (fifo_pop),
    .rdata (fifo_rdata),
    .full  (fifo_full),
    .empty (fifo_empty)
  );

  rrab_back #(.MAX_SIDE(MAX_SIDE)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (fifo_empty),
    .q_pop       (fifo_pop),
    .q_pixel     (b_pixel),
    .q_dx        (b_dx),
    .q_dy        (b_dy),
    .q_corner    (b_corner),
    .q_last      (b_last),
    .alpha       (alpha),
    .fill        (fill),
    .rsq         (rsq),
    .blend_valid (blend_valid),
    .blend_stall (blend_stall),
    .blend       (blend)
  );

`ifndef SYNTHESIS
  // the radius chain must settle before a pixel is taken after a write
  a_settle_after_cfg: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> !(pixel_valid && !pixel_stall))
    else $error("pixel accepted while radius chain settles");

  // queued transactions only leave through the back end
  a_queue_keeps: assert property (@(posedge clk) disable iff (rst)
    (!fifo_empty && !fifo_pop) |=> !fifo_empty)
    else $error("queue lost an entry");

  a_queue_fills: assert property (@(posedge clk) disable iff (rst)
    (fifo_push && fifo_empty) |=> !fifo_empty)
    else $error("queue dropped a push");
`endif

endmodule

`default_nettype wire
